>>> design/mau_pkg.sv
// Shared package for the modular arithmetic unit.
// Holds field widths, the reset modulus, operation codes and state types.
// No dependencies.
`timescale 1ns / 1ps

package mau_pkg;

    localparam int          VALUE_WIDTH_DEF = 31;
    localparam int          RAW_WIDTH       = 64;
    localparam int          EXP_WIDTH       = 63;
    localparam int          KIND_WIDTH      = 3;
    localparam int unsigned MODULUS_RESET   = 32'd1000000007;

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_REDUCE = 3'd0,
        KIND_ADD    = 3'd1,
        KIND_SUB    = 3'd2,
        KIND_NEG    = 3'd3,
        KIND_MUL    = 3'd4,
        KIND_DIV    = 3'd5,
        KIND_INV    = 3'd6,
        KIND_POW    = 3'd7
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_RAW,
        ST_RED_A,
        ST_RED_B,
        ST_DISPATCH,
        ST_MUL,
        ST_INV,
        ST_MUL_GO,
        ST_POW_STEP,
        ST_POW_WAIT
    } t_state;

    typedef enum logic [2:0] {
        INV_IDLE,
        INV_CHECK,
        INV_ALIGN,
        INV_SUB,
        INV_FIX
    } t_inv_state;

endpackage

>>> design/mau_reduce.sv
// Bit-serial reduction of an unsigned word modulo the modulus.
// Shifts one bit per cycle, MSB first, into a remainder kept below the modulus.
// Depends on mau_pkg for default widths.
`timescale 1ns / 1ps

module mau_reduce #(
    parameter int  W  = mau_pkg::VALUE_WIDTH_DEF,
    parameter int  RW = mau_pkg::RAW_WIDTH,
    localparam int CW = $clog2(RW + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [W-1:0]  i_modulus,
    input  logic [RW-1:0] i_word,
    input  logic [CW-1:0] i_count,
    output logic          o_done,
    output logic [W-1:0]  o_rem
);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [RW-1:0] r_word;
    logic [W-1:0]  r_rem;
    logic [W:0]    w_trial;
    logic [W:0]    w_diff;
    logic [W-1:0]  n_rem;

    // remainder stays below m, so one conditional subtract per bit suffices
    assign w_trial = {r_rem, r_word[RW-1]};
    assign w_diff  = w_trial - {1'b0, i_modulus};
    assign n_rem   = (w_trial >= {1'b0, i_modulus}) ? w_diff[W-1:0] : w_trial[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_word <= i_word;
            r_rem  <= '0;
            r_cnt  <= i_count;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_word <= {r_word[RW-2:0], 1'b0};
            r_cnt  <= r_cnt - CW'(1);
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> design/mau_mulmod.sv
// Bit-serial modular multiplier: double-and-add over the multiplier bits, MSB first.
// Both operands must be below the modulus.
// Depends on mau_pkg for the default width.
`timescale 1ns / 1ps

module mau_mulmod #(
    parameter int  W  = mau_pkg::VALUE_WIDTH_DEF,
    localparam int CW = $clog2(W + 1)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_modulus,
    input  logic [W-1:0] i_x,
    input  logic [W-1:0] i_y,
    output logic         o_done,
    output logic [W-1:0] o_prod
);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_x;
    logic [W-1:0]  r_y;
    logic [W-1:0]  r_acc;
    logic [W+1:0]  w_sum;
    logic [W+1:0]  w_m1;
    logic [W+1:0]  w_m2;
    logic [W+1:0]  w_red;

    // 2*acc + x stays below 3m: take off m or 2m
    assign w_sum = {1'b0, r_acc, 1'b0} + (r_y[W-1] ? {2'b00, r_x} : '0);
    assign w_m1  = {2'b00, i_modulus};
    assign w_m2  = {1'b0, i_modulus, 1'b0};

    always_comb begin
        if (w_sum >= w_m2) begin
            w_red = w_sum - w_m2;
        end else if (w_sum >= w_m1) begin
            w_red = w_sum - w_m1;
        end else begin
            w_red = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_acc <= '0;
            r_cnt <= CW'(W);
        end else if (r_busy) begin
            r_acc <= w_red[W-1:0];
            r_y   <= {r_y[W-2:0], 1'b0};
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

>>> design/mau_inverse.sv
// Extended Euclidean inverse modulo the modulus.
// Each quotient is found by shift-align and shift-subtract, one bit per cycle,
// updating the Bezout coefficient alongside. Depends on mau_pkg.
`timescale 1ns / 1ps

module mau_inverse #(
    parameter int  W  = mau_pkg::VALUE_WIDTH_DEF,
    localparam int XW = W + 3,
    localparam int SW = $clog2(W)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_modulus,
    input  logic [W-1:0] i_value,
    output logic         o_done,
    output logic [W-1:0] o_inv
);

    mau_pkg::t_inv_state r_state, n_state;

    logic                 r_done, n_done;
    logic [W-1:0]         r_a, n_a;
    logic [W-1:0]         r_b, n_b;
    logic [W-1:0]         r_d, n_d;
    logic [SW-1:0]        r_s, n_s;
    logic signed [XW-1:0] r_x, n_x;
    logic signed [XW-1:0] r_y, n_y;
    logic signed [XW-1:0] r_yd, n_yd;
    logic [W-1:0]         r_inv, n_inv;

    logic                 w_fits;
    logic                 w_sub_ok;
    logic [W-1:0]         w_bsub;
    logic signed [XW-1:0] w_xsub;
    logic signed [XW-1:0] w_fix;

    assign w_fits   = {r_d, 1'b0} <= {1'b0, r_b};
    assign w_sub_ok = r_d <= r_b;
    assign w_bsub   = w_sub_ok ? (r_b - r_d) : r_b;
    assign w_xsub   = w_sub_ok ? (r_x - r_yd) : r_x;
    assign w_fix    = r_x + $signed({3'b000, i_modulus});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mau_pkg::INV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_d   <= n_d;
        r_s   <= n_s;
        r_x   <= n_x;
        r_y   <= n_y;
        r_yd  <= n_yd;
        r_inv <= n_inv;
    end

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_a     = r_a;
        n_b     = r_b;
        n_d     = r_d;
        n_s     = r_s;
        n_x     = r_x;
        n_y     = r_y;
        n_yd    = r_yd;
        n_inv   = r_inv;
        unique case (r_state)
            mau_pkg::INV_IDLE: begin
                if (i_start) begin
                    n_a     = i_value;
                    n_b     = i_modulus;
                    n_x     = '0;
                    n_y     = XW'(1);
                    n_state = mau_pkg::INV_CHECK;
                end
            end
            mau_pkg::INV_CHECK: begin
                if (r_a == '0) begin
                    n_state = mau_pkg::INV_FIX;
                end else begin
                    n_d     = r_a;
                    n_yd    = r_y;
                    n_s     = '0;
                    n_state = mau_pkg::INV_ALIGN;
                end
            end
            mau_pkg::INV_ALIGN: begin
                // scale divisor up to the top quotient bit
                if (w_fits) begin
                    n_d  = {r_d[W-2:0], 1'b0};
                    n_yd = {r_yd[XW-2:0], 1'b0};
                    n_s  = r_s + SW'(1);
                end else begin
                    n_state = mau_pkg::INV_SUB;
                end
            end
            mau_pkg::INV_SUB: begin
                if (r_s == '0) begin
                    // quotient done: swap pairs for the next step
                    n_a     = w_bsub;
                    n_b     = r_a;
                    n_x     = r_y;
                    n_y     = w_xsub;
                    n_state = mau_pkg::INV_CHECK;
                end else begin
                    n_b  = w_bsub;
                    n_x  = w_xsub;
                    n_d  = {1'b0, r_d[W-1:1]};
                    n_yd = r_yd >>> 1;
                    n_s  = r_s - SW'(1);
                end
            end
            mau_pkg::INV_FIX: begin
                n_inv   = r_x[XW-1] ? w_fix[W-1:0] : r_x[W-1:0];
                n_done  = 1'b1;
                n_state = mau_pkg::INV_IDLE;
            end
            default: begin
                n_state = mau_pkg::INV_IDLE;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_inv  = r_inv;

endmodule

>>> design/modular_arithmetic_unit.sv
// Top level of the modular arithmetic unit: command sequencer and modulus register.
// Instantiates mau_reduce, two mau_mulmod units and mau_inverse; uses mau_pkg.
//
// Usage: drive the operation fields and raise start; the item is taken at an edge
// where start is high and busy is low. busy stays high until the result has been
// registered. The result appears on o_result for one cycle with o_valid high,
// and in that same cycle busy is already low, so the next command may follow.
// The receiver cannot stall; each result must be taken in its strobe cycle.
// The user must write the modulus via i_modulus_we / i_modulus_wdata while idle;
// the block itself does not enforce this. Per operation, from start to strobe:
//   modulus zero : result 0 strobed from idle, busy stays low
//   reduce       : the 64-bit bit-serial reducer, then the sign correction
//   add/sub/neg  : serial reduction of both operands, as for all rows below
//   mul          : then the serial multiplier
//   inv/div      : then shift-subtract Euclid steps; div multiplies by the inverse
//   pow          : then a multiply and a square per exponent bit to the top set bit
// One command is in flight at a time. Reset loads the modulus with 1000000007
// and returns the sequencer to idle with no strobe pending.
`timescale 1ns / 1ps

module modular_arithmetic_unit #(
    parameter int VALUE_WIDTH = mau_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [mau_pkg::KIND_WIDTH-1:0]      i_kind,
    input  logic [VALUE_WIDTH-1:0]              i_operand_a,
    input  logic [VALUE_WIDTH-1:0]              i_operand_b,
    input  logic signed [mau_pkg::RAW_WIDTH-1:0] i_raw_value,
    input  logic [mau_pkg::EXP_WIDTH-1:0]       i_exponent,
    input  logic                                i_modulus_we,
    input  logic [VALUE_WIDTH-1:0]              i_modulus_wdata,
    output logic                                o_valid,
    output logic [VALUE_WIDTH-1:0]              o_result
);

    localparam int W      = VALUE_WIDTH;
    localparam int RW     = mau_pkg::RAW_WIDTH;
    localparam int EW     = mau_pkg::EXP_WIDTH;
    localparam int RED_CW = $clog2(RW + 1);

    mau_pkg::t_state r_state, n_state;
    mau_pkg::t_kind  r_kind, n_kind;

    logic [W-1:0]  r_modulus;
    logic          r_out_valid, n_out_valid;
    logic [W-1:0]  r_result, n_result;
    logic [W-1:0]  r_a, n_a;
    logic [W-1:0]  r_b, n_b;
    logic          r_neg, n_neg;
    logic [EW-1:0] r_e, n_e;

    logic [RW-1:0]     w_mag;
    logic              w_red_start;
    logic [RW-1:0]     w_red_word;
    logic [RED_CW-1:0] w_red_count;
    logic              w_red_done;
    logic [W-1:0]      w_red_rem;
    logic              w_mul_start;
    logic              w_mul_done;
    logic [W-1:0]      w_mul_prod;
    logic              w_sq_start;
    logic              w_sq_done;
    logic [W-1:0]      w_sq_prod;
    logic              w_inv_start;
    logic [W-1:0]      w_inv_value;
    logic              w_inv_done;
    logic [W-1:0]      w_inv_out;
    logic [W:0]        w_add_sum;
    logic [W:0]        w_add_diff;
    logic [W-1:0]      w_add;
    logic [W-1:0]      w_sub;
    logic [W-1:0]      w_neg;

    assign w_mag = i_raw_value[RW-1] ? (~$unsigned(i_raw_value) + RW'(1))
                                     : $unsigned(i_raw_value);

    assign w_add_sum  = {1'b0, r_a} + {1'b0, r_b};
    assign w_add_diff = w_add_sum - {1'b0, r_modulus};
    assign w_add = (w_add_sum >= {1'b0, r_modulus}) ? w_add_diff[W-1:0] : w_add_sum[W-1:0];
    // wraps in W bits; the true value is below m
    assign w_sub = (r_a >= r_b) ? (r_a - r_b) : (r_a - r_b + r_modulus);
    assign w_neg = (r_a == '0) ? '0 : (r_modulus - r_a);

    assign w_inv_value = (r_kind == mau_pkg::KIND_DIV) ? r_b : r_a;

    mau_reduce #(
        .W  (W),
        .RW (RW)
    ) u_reduce (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_red_start),
        .i_modulus (r_modulus),
        .i_word    (w_red_word),
        .i_count   (w_red_count),
        .o_done    (w_red_done),
        .o_rem     (w_red_rem)
    );

    // r_a carries the base and r_b the accumulator during pow
    mau_mulmod #(
        .W (W)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_modulus (r_modulus),
        .i_x       (r_a),
        .i_y       (r_b),
        .o_done    (w_mul_done),
        .o_prod    (w_mul_prod)
    );

    mau_mulmod #(
        .W (W)
    ) u_square (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_sq_start),
        .i_modulus (r_modulus),
        .i_x       (r_a),
        .i_y       (r_a),
        .o_done    (w_sq_done),
        .o_prod    (w_sq_prod)
    );

    mau_inverse #(
        .W (W)
    ) u_inverse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_inv_start),
        .i_modulus (r_modulus),
        .i_value   (w_inv_value),
        .o_done    (w_inv_done),
        .o_inv     (w_inv_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mau_pkg::ST_IDLE;
            r_modulus   <= W'(mau_pkg::MODULUS_RESET);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_modulus_we) begin
                r_modulus <= i_modulus_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_kind   <= n_kind;
        r_a      <= n_a;
        r_b      <= n_b;
        r_neg    <= n_neg;
        r_e      <= n_e;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = 1'b0;
        n_result    = r_result;
        n_kind      = r_kind;
        n_a         = r_a;
        n_b         = r_b;
        n_neg       = r_neg;
        n_e         = r_e;
        w_red_start = 1'b0;
        w_red_word  = w_mag;
        w_red_count = RED_CW'(RW);
        w_mul_start = 1'b0;
        w_sq_start  = 1'b0;
        w_inv_start = 1'b0;
        unique case (r_state)
            mau_pkg::ST_IDLE: begin
                if (start) begin
                    n_kind = mau_pkg::t_kind'(i_kind);
                    n_b    = i_operand_b;
                    n_neg  = i_raw_value[RW-1];
                    n_e    = i_exponent;
                    if (r_modulus == '0) begin
                        n_out_valid = 1'b1;
                        n_result    = '0;
                    end else if (mau_pkg::t_kind'(i_kind) == mau_pkg::KIND_REDUCE) begin
                        w_red_start = 1'b1;
                        n_state     = mau_pkg::ST_RED_RAW;
                    end else begin
                        w_red_start = 1'b1;
                        w_red_word  = {i_operand_a, {(RW - W){1'b0}}};
                        w_red_count = RED_CW'(W);
                        n_state     = mau_pkg::ST_RED_A;
                    end
                end
            end
            mau_pkg::ST_RED_RAW: begin
                if (w_red_done) begin
                    n_out_valid = 1'b1;
                    n_result    = (r_neg && w_red_rem != '0) ? (r_modulus - w_red_rem)
                                                             : w_red_rem;
                    n_state     = mau_pkg::ST_IDLE;
                end
            end
            mau_pkg::ST_RED_A: begin
                if (w_red_done) begin
                    n_a         = w_red_rem;
                    w_red_start = 1'b1;
                    w_red_word  = {r_b, {(RW - W){1'b0}}};
                    w_red_count = RED_CW'(W);
                    n_state     = mau_pkg::ST_RED_B;
                end
            end
            mau_pkg::ST_RED_B: begin
                if (w_red_done) begin
                    n_b     = w_red_rem;
                    n_state = mau_pkg::ST_DISPATCH;
                end
            end
            mau_pkg::ST_DISPATCH: begin
                unique case (r_kind)
                    mau_pkg::KIND_REDUCE: begin
                        // reduce finishes in its own state
                        n_state = mau_pkg::ST_IDLE;
                    end
                    mau_pkg::KIND_ADD: begin
                        n_out_valid = 1'b1;
                        n_result    = w_add;
                        n_state     = mau_pkg::ST_IDLE;
                    end
                    mau_pkg::KIND_SUB: begin
                        n_out_valid = 1'b1;
                        n_result    = w_sub;
                        n_state     = mau_pkg::ST_IDLE;
                    end
                    mau_pkg::KIND_NEG: begin
                        n_out_valid = 1'b1;
                        n_result    = w_neg;
                        n_state     = mau_pkg::ST_IDLE;
                    end
                    mau_pkg::KIND_MUL: begin
                        w_mul_start = 1'b1;
                        n_state     = mau_pkg::ST_MUL;
                    end
                    mau_pkg::KIND_DIV, mau_pkg::KIND_INV: begin
                        w_inv_start = 1'b1;
                        n_state     = mau_pkg::ST_INV;
                    end
                    mau_pkg::KIND_POW: begin
                        // accumulator starts at 1 mod m
                        n_b     = (r_modulus == W'(1)) ? '0 : W'(1);
                        n_state = mau_pkg::ST_POW_STEP;
                    end
                    default: begin
                        n_state = mau_pkg::ST_IDLE;
                    end
                endcase
            end
            mau_pkg::ST_MUL: begin
                if (w_mul_done) begin
                    n_out_valid = 1'b1;
                    n_result    = w_mul_prod;
                    n_state     = mau_pkg::ST_IDLE;
                end
            end
            mau_pkg::ST_INV: begin
                if (w_inv_done) begin
                    if (r_kind == mau_pkg::KIND_DIV) begin
                        n_b     = w_inv_out;
                        n_state = mau_pkg::ST_MUL_GO;
                    end else begin
                        n_out_valid = 1'b1;
                        n_result    = w_inv_out;
                        n_state     = mau_pkg::ST_IDLE;
                    end
                end
            end
            mau_pkg::ST_MUL_GO: begin
                w_mul_start = 1'b1;
                n_state     = mau_pkg::ST_MUL;
            end
            mau_pkg::ST_POW_STEP: begin
                if (r_e == '0) begin
                    n_out_valid = 1'b1;
                    n_result    = r_b;
                    n_state     = mau_pkg::ST_IDLE;
                end else begin
                    w_mul_start = 1'b1;
                    w_sq_start  = 1'b1;
                    n_state     = mau_pkg::ST_POW_WAIT;
                end
            end
            mau_pkg::ST_POW_WAIT: begin
                // both units run the same count and finish together
                if (w_mul_done && w_sq_done) begin
                    if (r_e[0]) begin
                        n_b = w_mul_prod;
                    end
                    n_a     = w_sq_prod;
                    n_e     = {1'b0, r_e[EW-1:1]};
                    n_state = mau_pkg::ST_POW_STEP;
                end
            end
            default: begin
                n_state = mau_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != mau_pkg::ST_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

>>> tb/sv/tb_modular_arithmetic_unit.sv
// Self-checking testbench for modular_arithmetic_unit: directed edge cases, then random beats.
// Uses mau_pkg for widths, reset modulus and operation codes; the predictor runs inside this file.
`timescale 1ns / 1ps

module tb_modular_arithmetic_unit;

    import mau_pkg::*;

    localparam int VW = VALUE_WIDTH_DEF;
    localparam logic [VW-1:0] MOD_MAX = {VW{1'b1}};

    typedef struct {
        t_kind               kind;
        logic [VW-1:0]       operand_a;
        logic [VW-1:0]       operand_b;
        logic [RAW_WIDTH-1:0] raw_value;
        logic [EXP_WIDTH-1:0] exponent;
    } arith_cmd_t;

    typedef struct {
        t_kind         kind;
        logic [VW-1:0] result;
    } pending_result_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [KIND_WIDTH-1:0]   i_kind;
    logic [VW-1:0]           i_operand_a;
    logic [VW-1:0]           i_operand_b;
    logic signed [RAW_WIDTH-1:0] i_raw_value;
    logic [EXP_WIDTH-1:0]    i_exponent;
    logic                    i_modulus_we;
    logic [VW-1:0]           i_modulus_wdata;
    logic                    o_valid;
    logic [VW-1:0]           o_result;

    pending_result_t pending_results[$];
    logic [VW-1:0]   model_modulus;
    int unsigned     error_count;
    bit              idle_enabled;

    modular_arithmetic_unit #(
        .VALUE_WIDTH(VW)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_raw_value    (i_raw_value),
        .i_exponent     (i_exponent),
        .i_modulus_we   (i_modulus_we),
        .i_modulus_wdata(i_modulus_wdata),
        .o_valid        (o_valid),
        .o_result       (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(64'd250_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint unsigned euclid_inverse(longint unsigned v, longint unsigned m);
        longint ra, rb, xa, ya, q, t, sm;
        sm = m;
        ra = v;
        rb = sm;
        xa = 0;
        ya = 1;
        while (ra != 0) begin
            q  = rb / ra;
            rb = rb - q * ra;
            xa = xa - q * ya;
            t  = ra; ra = rb; rb = t;
            t  = xa; xa = ya; ya = t;
        end
        xa = xa % sm;
        if (xa < 0) xa = xa + sm;
        return xa;
    endfunction

    function automatic logic [VW-1:0] compute_modular_result(arith_cmd_t c,
                                                            logic [VW-1:0] modulus);
        longint unsigned m, a, b, r, mag, base, e;
        m = modulus;
        r = 0;
        if (m == 0) return '0;
        a = c.operand_a % m;
        b = c.operand_b % m;
        case (c.kind)
            KIND_REDUCE: begin
                if (!c.raw_value[RAW_WIDTH-1]) begin
                    r = c.raw_value % m;
                end else begin
                    mag = ~c.raw_value + 64'd1;
                    r   = mag % m;
                    r   = (r == 0) ? 0 : m - r;
                end
            end
            KIND_ADD: r = (a + b) % m;
            KIND_SUB: r = (a >= b) ? a - b : a + m - b;
            KIND_NEG: r = (a == 0) ? 0 : m - a;
            KIND_MUL: r = (a * b) % m;
            KIND_DIV: r = (a * euclid_inverse(b, m)) % m;
            KIND_INV: r = euclid_inverse(a, m);
            default: begin
                base = a;
                e    = c.exponent;
                r    = 1 % m;
                while (e != 0) begin
                    if (e[0]) r = (r * base) % m;
                    base = (base * base) % m;
                    e    = e >> 1;
                end
            end
        endcase
        return r[VW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        $display("[%0t] ERROR %s", $realtime, msg);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        pending_result_t want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat %0d", o_result));
            end else begin
                want = pending_results.pop_front();
                if (o_result !== want.result)
                    report_mismatch($sformatf("%s result: got %0d want %0d",
                                              want.kind.name(), o_result, want.result));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int unsigned r;
        if (!idle_enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(30, 150);
    endfunction

    // Called right after a rising edge; returns at the edge that takes the beat.
    task automatic issue_cmd(arith_cmd_t c);
        pending_result_t entry;
        int gap;
        start       <= 1'b1;
        i_kind      <= c.kind;
        i_operand_a <= c.operand_a;
        i_operand_b <= c.operand_b;
        i_raw_value <= c.raw_value;
        i_exponent  <= c.exponent;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        entry.kind   = c.kind;
        entry.result = compute_modular_result(c, model_modulus);
        pending_results.push_back(entry);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_pending();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_modulus(logic [VW-1:0] value);
        drain_pending();
        i_modulus_we    <= 1'b1;
        i_modulus_wdata <= value;
        @(posedge i_clk);
        i_modulus_we    <= 1'b0;
        model_modulus    = value;
    endtask

    function automatic arith_cmd_t make_cmd(t_kind kind, logic [VW-1:0] a, logic [VW-1:0] b,
                                            logic [RAW_WIDTH-1:0] raw,
                                            logic [EXP_WIDTH-1:0] e);
        arith_cmd_t c;
        c.kind      = kind;
        c.operand_a = a;
        c.operand_b = b;
        c.raw_value = raw;
        c.exponent  = e;
        return c;
    endfunction

    function automatic logic [VW-1:0] pick_operand();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (model_modulus == 0 || r < 8) return $urandom();
        if (r < 14) return '0;
        if (r < 20) return model_modulus - 1;
        return $urandom_range(0, model_modulus - 1);
    endfunction

    function automatic logic [RAW_WIDTH-1:0] pick_raw();
        int unsigned r;
        logic [RAW_WIDTH-1:0] v;
        r = $urandom_range(0, 99);
        v = {$urandom(), $urandom()};
        case (r)
            0: v = {1'b1, {(RAW_WIDTH-1){1'b0}}};
            1: v = {1'b0, {(RAW_WIDTH-1){1'b1}}};
            2: v = '1;
            3: v = '0;
            4: v = model_modulus * $urandom_range(0, 1000);
            5: v = -(model_modulus * $urandom_range(1, 1000));
            default: if (r < 40) v = $signed($urandom()); // narrow values, both signs
        endcase
        return v;
    endfunction

    // Mostly short exponents keep power latency low; a few go to full width.
    function automatic logic [EXP_WIDTH-1:0] pick_exponent();
        int unsigned r, len;
        logic [63:0] v;
        r = $urandom_range(0, 99);
        if (r < 90) len = $urandom_range(0, 16);
        else if (r < 98) len = $urandom_range(17, 40);
        else len = EXP_WIDTH;
        v = {$urandom(), $urandom()};
        if (len < 64) v = v & ((64'd1 << len) - 1);
        return v[EXP_WIDTH-1:0];
    endfunction

    function automatic arith_cmd_t make_random_cmd();
        return make_cmd(t_kind'($urandom_range(0, 7)), pick_operand(), pick_operand(),
                        pick_raw(), pick_exponent());
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_default_modulus_edges();
        logic [VW-1:0] m1;
        idle_enabled = 1'b1;
        m1 = model_modulus - 1;
        issue_cmd(make_cmd(KIND_REDUCE, 0, 0, {1'b0, {(RAW_WIDTH-1){1'b1}}}, 0));
        issue_cmd(make_cmd(KIND_REDUCE, 0, 0, {1'b1, {(RAW_WIDTH-1){1'b0}}}, 0));
        issue_cmd(make_cmd(KIND_REDUCE, 0, 0, '1, 0));
        issue_cmd(make_cmd(KIND_REDUCE, 0, 0, -64'sd1000000007, 0));
        issue_cmd(make_cmd(KIND_ADD, m1, m1, 0, 0));
        issue_cmd(make_cmd(KIND_SUB, 0, m1, 0, 0));
        issue_cmd(make_cmd(KIND_NEG, 0, 5, 0, 0));
        issue_cmd(make_cmd(KIND_NEG, 1, 0, 0, 0));
        issue_cmd(make_cmd(KIND_MUL, m1, m1, 0, 0));
        issue_cmd(make_cmd(KIND_MUL, MOD_MAX, MOD_MAX, 0, 0));  // unreduced operands
        issue_cmd(make_cmd(KIND_DIV, 12345, 0, 0, 0));          // divide by zero
        issue_cmd(make_cmd(KIND_DIV, 1, 3, 0, 0));
        issue_cmd(make_cmd(KIND_INV, 0, 0, 0, 0));
        issue_cmd(make_cmd(KIND_INV, m1, 0, 0, 0));
        issue_cmd(make_cmd(KIND_POW, 0, 0, 0, 0));              // zero to the zero
        issue_cmd(make_cmd(KIND_POW, 5, 0, 0, 0));
        issue_cmd(make_cmd(KIND_POW, 2, 0, 0, model_modulus - 2));
        issue_cmd(make_cmd(KIND_POW, m1, 0, 0, '1));
    endtask

    task automatic test_degenerate_moduli();
        write_modulus('0);
        issue_cmd(make_cmd(KIND_ADD, 7, 9, 0, 0));
        issue_cmd(make_cmd(KIND_POW, 3, 0, 0, 0));
        issue_cmd(make_cmd(KIND_REDUCE, 0, 0, -64'sd5, 0));
        write_modulus(1);
        issue_cmd(make_cmd(KIND_POW, 0, 0, 0, 0));
        issue_cmd(make_cmd(KIND_INV, 1, 0, 0, 0));
        issue_cmd(make_cmd(KIND_REDUCE, 0, 0, {1'b1, {(RAW_WIDTH-1){1'b0}}}, 0));
        write_modulus(2);
        issue_cmd(make_cmd(KIND_NEG, 1, 0, 0, 0));
        issue_cmd(make_cmd(KIND_DIV, 1, 1, 0, 0));
        write_modulus(MOD_MAX);
        issue_cmd(make_cmd(KIND_ADD, MOD_MAX, MOD_MAX - 1, 0, 0));
        issue_cmd(make_cmd(KIND_INV, MOD_MAX - 1, 0, 0, 0));
    endtask

    // composite modulus: where the gcd is above one, the inverse is only the Euclidean coefficient
    task automatic test_composite_modulus();
        write_modulus(31'd1000000000);
        issue_cmd(make_cmd(KIND_INV, 2, 0, 0, 0));
        issue_cmd(make_cmd(KIND_DIV, 7, 250, 0, 0));
        issue_cmd(make_cmd(KIND_INV, 999999999, 0, 0, 0));
    endtask

    task automatic test_random_ops();
        logic [VW-1:0] moduli[8];
        moduli[0] = MODULUS_RESET;
        moduli[1] = MOD_MAX;
        moduli[2] = 31'd65521;
        moduli[3] = 31'd3;
        moduli[4] = 31'd1000000000;
        moduli[5] = 31'd2;
        moduli[6] = $urandom_range(2, 32'h7FFF_FFFF);
        moduli[7] = $urandom_range(2, 32'h7FFF_FFFF);
        for (int phase = 0; phase < 8; phase++) begin
            write_modulus(moduli[phase]);
            idle_enabled = (phase % 3) != 1;
            for (int n = 0; n < 250; n++) begin
                issue_cmd(make_random_cmd());
                if ($urandom_range(0, 99) == 0) drain_pending();
            end
        end
    endtask

    initial begin
        int unsigned wait_cycles;
        error_count     = 0;
        idle_enabled    = 1'b1;
        model_modulus   = MODULUS_RESET;
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_kind          <= KIND_REDUCE;
        i_operand_a     <= '0;
        i_operand_b     <= '0;
        i_raw_value     <= '0;
        i_exponent      <= '0;
        i_modulus_we    <= 1'b0;
        i_modulus_wdata <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_modulus_edges();
        test_degenerate_moduli();
        test_composite_modulus();
        test_random_ops();

        start <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 5000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        // watch for stray strobes past the longest power latency
        repeat (2500) @(posedge i_clk);

        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
